### sv/skh_pkg.sv
// Shared types, constants and helper functions for the selectable key hash.
// Used by skh_byte_lane and selectable_key_hash_64.
// No dependencies.
package skh_pkg;

  // Pipeline shape
  localparam int unsigned NumStages     = 7;
  localparam int unsigned NumByteStages = 4;
  localparam int unsigned BytesPerStage = 2;

  // Hash kinds, as written to the hash_kind register
  typedef enum logic [2:0] {
    KindSplitmix = 3'd0,
    KindMurmur   = 3'd1,
    KindGolden   = 3'd2,
    KindFnv1a    = 3'd3,
    KindCrcPair  = 3'd4
  } hash_kind_e;

  // Register indexes on the write port
  typedef enum logic [0:0] {
    RegHashKind = 1'b0,
    RegSeed     = 1'b1
  } cfg_reg_e;

  // Mixing constants
  localparam logic [63:0] MixC1       = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixC2       = 64'h94d049bb133111eb;
  localparam logic [63:0] MurC1       = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MurC2       = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] Golden      = 64'h9e3779b97f4a7c13;
  localparam logic [63:0] FnvBasis    = 64'hcbf29ce484222325;
  // FNV prime is 2^40 + FnvPrimeLow
  localparam int unsigned FnvPrimeShift = 40;
  localparam logic [63:0] FnvPrimeLow = 64'h00000000000001b3;
  localparam logic [31:0] CrcSeedLo   = 32'h0b56b4a9;
  localparam logic [31:0] CrcSeedHi   = 32'h04c11db7;
  localparam logic [31:0] CrcPolyRefl = 32'h82f63b78;
  localparam logic [63:0] CrcFinalMul = 64'h2545f4914f6cdd1d;

  typedef logic [31:0] crc_tbl_t [256];

  // Build the reflected CRC32C byte table at elaboration
  function automatic crc_tbl_t crc_table_gen();
    crc_tbl_t    tbl;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int b = 0; b < 8; b++) begin
        if (c[0]) begin
          c = (c >> 1) ^ CrcPolyRefl;
        end else begin
          c = c >> 1;
        end
      end
      tbl[i] = c;
    end
    return tbl;
  endfunction

  localparam crc_tbl_t CrcTable = crc_table_gen();

  // One CRC32C byte update, low bit first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] d);
    return (crc >> 8) ^ CrcTable[crc[7:0] ^ d];
  endfunction

  // One FNV-1a byte round; the prime multiply is a shift plus a small constant product
  function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] d);
    logic [63:0] x;
    x = h ^ {56'b0, d};
    return (x << FnvPrimeShift) + x * FnvPrimeLow;
  endfunction

endpackage

### sv/skh_mul64.sv
// Two-stage 64x64 multiplier that keeps the low 64 bits of the product.
// Cut into 32x32 partial products, summed in the second stage.
// Depends on no package.
module skh_mul64 (
  input  logic        clk_i,
  input  logic        pp_en_i,
  input  logic        sum_en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] ll_q;
  logic [31:0] hl_q;
  logic [31:0] lh_q;
  logic [63:0] prod_q;

  // Partial products; the cross terms only reach the upper half
  always_ff @(posedge clk_i) begin
    if (pp_en_i) begin
      ll_q <= {32'b0, a_i[31:0]} * {32'b0, b_i[31:0]};
      hl_q <= 32'(a_i[63:32] * b_i[31:0]);
      lh_q <= 32'(a_i[31:0] * b_i[63:32]);
    end
  end

  // Sum the partial products, wrapping at 64 bits
  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      prod_q <= ll_q + {hl_q + lh_q, 32'b0};
    end
  end

  assign prod_o = prod_q;

endmodule

### sv/skh_byte_lane.sv
// Byte-wise hash lane: FNV-1a and two CRC32C runs over the 8 key bytes.
// Two bytes per register stage, four stages. Depends on skh_pkg.
module skh_byte_lane (
  input  logic                                clk_i,
  input  logic [skh_pkg::NumByteStages-1:0]   en_i,
  input  logic [63:0]                         key_i,
  output logic [63:0]                         fnv_o,
  output logic [63:0]                         crc_o
);
  import skh_pkg::*;

  logic [63:0] fnv_in  [NumByteStages];
  logic [31:0] lo_in   [NumByteStages];
  logic [31:0] hi_in   [NumByteStages];
  logic [63:0] key_in  [NumByteStages];
  logic [63:0] fnv_d   [NumByteStages];
  logic [31:0] lo_d    [NumByteStages];
  logic [31:0] hi_d    [NumByteStages];
  logic [63:0] fnv_q   [NumByteStages];
  logic [31:0] lo_q    [NumByteStages];
  logic [31:0] hi_q    [NumByteStages];
  logic [63:0] key_q   [NumByteStages-1];

  // Stage inputs: the first stage starts from the basis and seeds
  always_comb begin
    fnv_in[0] = FnvBasis;
    lo_in[0]  = CrcSeedLo;
    hi_in[0]  = CrcSeedHi;
    key_in[0] = key_i;
    for (int i = 1; i < NumByteStages; i++) begin
      fnv_in[i] = fnv_q[i-1];
      lo_in[i]  = lo_q[i-1];
      hi_in[i]  = hi_q[i-1];
      key_in[i] = key_q[i-1];
    end
  end

  // Two byte rounds per stage, low byte first
  always_comb begin
    for (int i = 0; i < NumByteStages; i++) begin
      fnv_d[i] = fnv_in[i];
      lo_d[i]  = lo_in[i];
      hi_d[i]  = hi_in[i];
      for (int j = 0; j < BytesPerStage; j++) begin
        fnv_d[i] = fnv_round(fnv_d[i], key_in[i][8*(BytesPerStage*i+j) +: 8]);
        lo_d[i]  = crc_byte(lo_d[i], key_in[i][8*(BytesPerStage*i+j) +: 8]);
        hi_d[i]  = crc_byte(hi_d[i], key_in[i][8*(BytesPerStage*i+j) +: 8]);
      end
    end
  end

  // Stage registers; load when the stage advances
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumByteStages; i++) begin
      if (en_i[i]) begin
        fnv_q[i] <= fnv_d[i];
        lo_q[i]  <= lo_d[i];
        hi_q[i]  <= hi_d[i];
      end
    end
    for (int i = 0; i < NumByteStages - 1; i++) begin
      if (en_i[i]) begin
        key_q[i] <= key_in[i];
      end
    end
  end

  assign fnv_o = fnv_q[NumByteStages-1];
  assign crc_o = {hi_q[NumByteStages-1], lo_q[NumByteStages-1]};

endmodule

### sv/selectable_key_hash_64.sv
// Top level of the selectable 64-bit key hash: seven-stage pipeline.
// Depends on skh_pkg, skh_mul64 and skh_byte_lane.
//
//   channel   direction   fields (low bit up)
//   s_axis    in          tdata: key[63:0]
//   m_axis    out         tdata: hash[63:0]
//   cfg       in          index 0 hash_kind[2:0], index 1 seed[63:0]
//
// One key enters per cycle unless the output stalls while every stage is full.
// The pipeline depth is set by the two chained 64-bit multiplies (two stages each)
// and the byte lane, which takes two key bytes per stage.
// Reset clears the stage valid bits and the configuration registers only; no clearing pass.
// A stall holds each full stage with no empty stage after it; earlier stages keep filling.
module selectable_key_hash_64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // Key stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[63:0]
  // Hash stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // hash[63:0]
);
  import skh_pkg::*;

  hash_kind_e  hash_kind_q;
  logic [63:0] seed_q;

  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   stg_rdy;

  // Per-stage payload
  logic [63:0] key0_q, key1_q, key2_q, key3_q, key4_q, key5_q;
  hash_kind_e  kind0_q, kind1_q, kind2_q, kind3_q, kind4_q, kind5_q;
  logic [63:0] mixa_d, mixa_q;
  logic [63:0] mul1_c;
  logic [63:0] mul1_p;
  logic [63:0] y3_q, y4_q, y5_q;
  logic [63:0] fnv3, crc3;
  logic [63:0] fnv4_q, fnv5_q;
  logic [63:0] mixb;
  logic [63:0] mul2_c;
  logic [63:0] mul2_p;
  logic [63:0] hash_d, hash_q;
  logic [30:0] top0, top3, top5;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_kind_q <= KindSplitmix;
      seed_q      <= 64'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegHashKind: hash_kind_q <= hash_kind_e'(cfg_wdata_i[2:0]);
        RegSeed:     seed_q      <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // Ready chain: a stage loads when it is empty or its successor moves
  always_comb begin
    stg_rdy[NumStages] = m_axis_tready;
    for (int i = NumStages - 1; i >= 0; i--) begin
      stg_rdy[i] = !vld_q[i] || stg_rdy[i+1];
    end
  end

  assign s_axis_tready = stg_rdy[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (stg_rdy[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Stage 0: pre-mix operand for the first multiply
  assign top0 = s_axis_tdata[63:33];

  always_comb begin
    unique case (hash_kind_q)
      KindSplitmix: mixa_d = s_axis_tdata ^ (s_axis_tdata >> 30);
      KindMurmur:   mixa_d = s_axis_tdata ^ seed_q ^ {33'b0, top0};
      default:      mixa_d = s_axis_tdata;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      key0_q  <= s_axis_tdata;
      kind0_q <= hash_kind_q;
      mixa_q  <= mixa_d;
    end
  end

  // Stages 1-2: first multiply
  always_comb begin
    unique case (kind0_q)
      KindSplitmix: mul1_c = MixC1;
      KindMurmur:   mul1_c = MurC1;
      default:      mul1_c = Golden;
    endcase
  end

  skh_mul64 u_mul1 (
    .clk_i    (clk_i),
    .pp_en_i  (stg_rdy[1]),
    .sum_en_i (stg_rdy[2]),
    .a_i      (mixa_q),
    .b_i      (mul1_c),
    .prod_o   (mul1_p)
  );

  // Stages 0-3: FNV-1a and CRC pair over the key bytes
  skh_byte_lane u_lane (
    .clk_i (clk_i),
    .en_i  (stg_rdy[NumByteStages-1:0]),
    .key_i (s_axis_tdata),
    .fnv_o (fnv3),
    .crc_o (crc3)
  );

  // Carry key and kind along the pipe
  always_ff @(posedge clk_i) begin
    if (stg_rdy[1]) begin
      key1_q  <= key0_q;
      kind1_q <= kind0_q;
    end
    if (stg_rdy[2]) begin
      key2_q  <= key1_q;
      kind2_q <= kind1_q;
    end
    if (stg_rdy[3]) begin
      key3_q  <= key2_q;
      kind3_q <= kind2_q;
      y3_q    <= mul1_p;
    end
    if (stg_rdy[4]) begin
      key4_q  <= key3_q;
      kind4_q <= kind3_q;
      y4_q    <= y3_q;
      fnv4_q  <= fnv3;
    end
    if (stg_rdy[5]) begin
      key5_q  <= key4_q;
      kind5_q <= kind4_q;
      y5_q    <= y4_q;
      fnv5_q  <= fnv4_q;
    end
  end

  // Stage 4: mid-mix operand and constant for the second multiply
  assign top3 = key3_q[63:33];

  always_comb begin
    unique case (kind3_q)
      KindSplitmix: begin
        mixb   = y3_q ^ (y3_q >> 27);
        mul2_c = MixC2;
      end
      KindMurmur: begin
        mixb   = y3_q ^ {33'b0, top3};
        mul2_c = MurC2;
      end
      KindGolden: begin
        mixb   = {32'b0, key3_q[63:32]};
        mul2_c = Golden;
      end
      default: begin
        mixb   = crc3;
        mul2_c = CrcFinalMul;
      end
    endcase
  end

  // Stages 4-5: second multiply
  skh_mul64 u_mul2 (
    .clk_i    (clk_i),
    .pp_en_i  (stg_rdy[4]),
    .sum_en_i (stg_rdy[5]),
    .a_i      (mixb),
    .b_i      (mul2_c),
    .prod_o   (mul2_p)
  );

  // Stage 6: final mix and output register
  assign top5 = key5_q[63:33];

  always_comb begin
    unique case (kind5_q)
      KindSplitmix: hash_d = mul2_p ^ (mul2_p >> 31);
      KindMurmur:   hash_d = mul2_p ^ {33'b0, top5};
      KindGolden:   hash_d = mul2_p ^ y5_q;
      KindFnv1a:    hash_d = fnv5_q;
      KindCrcPair:  hash_d = mul2_p;
      default:      hash_d = 64'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[6]) begin
      hash_q <= hash_d;
    end
  end

  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = hash_q;

  // Input backpressure only when every stage is full
  a_full_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> &vld_q)
    else $error("input stalled while a stage is empty");

  // A beat in the last inner stage reaches the output when it moves
  a_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-2] && stg_rdy[NumStages-1] |=> m_axis_tvalid)
    else $error("beat lost before the output register");

  // A bubble moving into the output register leaves it empty
  a_no_repeat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NumStages-2] && stg_rdy[NumStages-1] |=> !m_axis_tvalid)
    else $error("output beat repeated or invented");

endmodule
